// File: hdl/fdf_pkg.sv
package fdf_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned BOX_BITS   = COORD_BITS + 1;
  localparam int unsigned SCALE_SH   = 56 - 2 * COORD_BITS;
  localparam int unsigned CW         = 64;  // CORDIC x/y datapath
  localparam int unsigned ZW         = 34;  // angle accumulator, 2^-24 degree
  localparam int unsigned ACC_FRAC   = 24;
  localparam int unsigned STEPS      = 28;
  localparam int unsigned ANG_BITS   = 9;
  localparam int unsigned PCT_BITS   = 7;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INNER_MIN = 3'd0,
    CFG_INNER_MAX = 3'd1,
    CFG_DIR_MIN   = 3'd2,
    CFG_DIR_MAX   = 3'd3,
    CFG_LEN_MIN   = 3'd4,
    CFG_LEN_MAX   = 3'd5
  } fdf_cfg_e;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic signed [ZW-1:0] ATAN_TAB [STEPS] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115,
    34'sd57,        34'sd29,        34'sd14,        34'sd7
  };

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] far_x;
    logic [COORD_BITS-1:0] far_y;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [BOX_BITS-1:0]   box_width;
    logic [BOX_BITS-1:0]   box_height;
  } fdf_item_t;

  typedef struct packed {
    logic                  is_tip;
    logic [COORD_BITS-1:0] tip_x;
    logic [COORD_BITS-1:0] tip_y;
  } fdf_result_t;

  typedef struct packed {
    logic [ANG_BITS-1:0] inner_min;
    logic [ANG_BITS-1:0] inner_max;
    logic [ANG_BITS-1:0] dir_min;
    logic [ANG_BITS-1:0] dir_max;
    logic [PCT_BITS-1:0] len_min;
    logic [PCT_BITS-1:0] len_max;
  } fdf_cfg_t;

  // per-item tags that ride alongside the CORDIC chains
  typedef struct packed {
    logic                  vld;
    logic                  bad;
    logic                  len_ok;
    logic [COORD_BITS-1:0] tip_x;
    logic [COORD_BITS-1:0] tip_y;
  } fdf_side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } fdf_vec_t;

endpackage

// File: hdl/fingertip_defect_filter_unit.sv
// Fingertip filter for convexity defects of a hand contour.
//
// Command channel: an item (start, end and far point plus hull box) is taken
// at each rising edge with start high; busy stays low, so one item can enter
// every cycle.
// Result channel: done_o pulses for one cycle with result_o (is_tip and the
// start point). There is no back-pressure; the receiver must take it.
// Pipeline: six front stages build the squared distances, the cross and dot
// products and the length window, then two rows of 28 CORDIC cells (one row
// for the direction angle, one for the inner angle) step in parallel, and
// one stage rounds and compares.
// Throughput: one item per cycle, set by the fully pipelined cell rows.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data;
// ready is always high. Write only while no item is in flight.
// Reset: asynchronous, active low; clears all valid bits and loads the
// limit registers with 200/300/180/359 degrees and 10/80 percent.
module fingertip_defect_filter_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  fdf_pkg::fdf_item_t      item_i,
  output logic                    done_o,
  output fdf_pkg::fdf_result_t    result_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [fdf_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [fdf_pkg::ANG_BITS-1:0]     cfg_data_i
);
  import fdf_pkg::*;

  localparam int unsigned RSH = ACC_FRAC - ANGLE_FRAC_BITS;

  // configuration registers
  fdf_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner_min <= ANG_BITS'(200);
      cfg_q.inner_max <= ANG_BITS'(300);
      cfg_q.dir_min   <= ANG_BITS'(180);
      cfg_q.dir_max   <= ANG_BITS'(359);
      cfg_q.len_min   <= PCT_BITS'(10);
      cfg_q.len_max   <= PCT_BITS'(80);
    end else if (cfg_valid_i) begin
      case (fdf_cfg_e'(cfg_index_i))
        CFG_INNER_MIN: cfg_q.inner_min <= cfg_data_i;
        CFG_INNER_MAX: cfg_q.inner_max <= cfg_data_i;
        CFG_DIR_MIN:   cfg_q.dir_min   <= cfg_data_i;
        CFG_DIR_MAX:   cfg_q.dir_max   <= cfg_data_i;
        CFG_LEN_MIN:   cfg_q.len_min   <= cfg_data_i[PCT_BITS-1:0];
        CFG_LEN_MAX:   cfg_q.len_max   <= cfg_data_i[PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // front stages
  fdf_vec_t  dir_v [STEPS+1];
  fdf_vec_t  inr_v [STEPS+1];
  fdf_side_t side_v;
  fdf_side_t side_q [1:STEPS];

  fdf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start && !busy),
    .item_i (item_i),
    .cfg_i  (cfg_q),
    .dir_o  (dir_v[0]),
    .inr_o  (inr_v[0]),
    .side_o (side_v)
  );

  // two rows of CORDIC cells
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    fdf_cordic_cell #(.STEP(g)) u_dir (
      .clk_i (clk_i),
      .v_i   (dir_v[g]),
      .v_o   (dir_v[g+1])
    );
    fdf_cordic_cell #(.STEP(g)) u_inr (
      .clk_i (clk_i),
      .v_i   (inr_v[g]),
      .v_o   (inr_v[g+1])
    );
  end

  // tags delayed alongside the cell rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= STEPS; i++) side_q[i] <= '0;
    end else begin
      side_q[1] <= side_v;
      for (int i = 2; i <= STEPS; i++) side_q[i] <= side_q[i-1];
    end
  end

  // rounding (half up) and strict window compares
  function automatic logic signed [ZW-1:0] lim(input logic [ANG_BITS-1:0] v);
    logic signed [ZW-1:0] d;
    d = $signed(ZW'(v)) - ZW'(180);
    return d <<< ANGLE_FRAC_BITS;
  endfunction

  logic signed [ZW-1:0] dir_ang, inr_ang;
  logic                 dir_ok, inr_ok;
  fdf_side_t            last;

  assign last    = side_q[STEPS];
  assign dir_ang = (dir_v[STEPS].z + (ZW'(1) <<< (RSH - 1))) >>> RSH;
  assign inr_ang = (inr_v[STEPS].z + (ZW'(1) <<< (RSH - 1))) >>> RSH;
  assign dir_ok  = (dir_ang > lim(cfg_q.dir_min)) && (dir_ang < lim(cfg_q.dir_max));
  assign inr_ok  = (inr_ang > lim(cfg_q.inner_min)) && (inr_ang < lim(cfg_q.inner_max));

  logic        done_q;
  fdf_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.is_tip <= !last.bad && last.len_ok && dir_ok && inr_ok;
    res_q.tip_x  <= last.tip_x;
    res_q.tip_y  <= last.tip_y;
  end

  assign done_o   = done_q;
  assign result_o = res_q;
endmodule

// File: hdl/fdf_cordic_cell.sv
module fdf_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  fdf_pkg::fdf_vec_t v_i,
  output fdf_pkg::fdf_vec_t v_o
);
  import fdf_pkg::*;

  fdf_vec_t v_d, v_q;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    xs = v_i.x >>> STEP;
    ys = v_i.y >>> STEP;
    if (!v_i.y[CW-1]) begin
      v_d.x = v_i.x + ys;
      v_d.y = v_i.y - xs;
      v_d.z = v_i.z + ATAN_TAB[STEP];
    end else begin
      v_d.x = v_i.x - ys;
      v_d.y = v_i.y + xs;
      v_d.z = v_i.z - ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;
endmodule

// File: hdl/fdf_front.sv
module fdf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  fdf_pkg::fdf_item_t item_i,
  input  fdf_pkg::fdf_cfg_t  cfg_i,
  output fdf_pkg::fdf_vec_t  dir_o,
  output fdf_pkg::fdf_vec_t  inr_o,
  output fdf_pkg::fdf_side_t side_o
);
  import fdf_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;        // point difference
  localparam int unsigned VW = COORD_BITS + 2;        // direction vector
  localparam int unsigned SW = 2 * COORD_BITS;        // one square
  localparam int unsigned QW = 2 * COORD_BITS + 1;    // squared distance
  localparam int unsigned LW = QW + 14;               // distance^2 * 10000
  localparam int unsigned HW = PCT_BITS + BOX_BITS;   // pct * height
  localparam int unsigned PW = 2 * DW;                // one product
  localparam int unsigned RW = PW + 1;                // cross / dot

  typedef struct packed {
    logic [COORD_BITS-1:0] sx, sy, ex, ey, fx, fy;
    logic [BOX_BITS-1:0]   bh;
    logic signed [VW-1:0]  dx, dy;
    logic                  dzero;
  } s12_t;

  // stage 1: squares and direction vector
  s12_t s1_d, s1_q, s2_q;
  logic v1_q, v2_q;
  logic [SW-1:0] q1_d [4];
  logic [SW-1:0] q1_q [4];
  logic signed [DW-1:0] dsx, dsy, dex, dey;
  logic [COORD_BITS:0] cx, cy;
  logic signed [PW-1:0] sq [4];

  always_comb begin
    cx = (COORD_BITS+1)'(item_i.box_left)
         + (COORD_BITS+1)'(item_i.box_width[BOX_BITS-1:1]);
    cy = (COORD_BITS+1)'(item_i.box_top)
         + (COORD_BITS+1)'(item_i.box_height[BOX_BITS-1:1]);
    dsx = $signed({1'b0, item_i.start_x}) - $signed({1'b0, item_i.far_x});
    dsy = $signed({1'b0, item_i.start_y}) - $signed({1'b0, item_i.far_y});
    dex = $signed({1'b0, item_i.end_x})   - $signed({1'b0, item_i.far_x});
    dey = $signed({1'b0, item_i.end_y})   - $signed({1'b0, item_i.far_y});
    sq[0] = dsx * dsx;
    sq[1] = dsy * dsy;
    sq[2] = dex * dex;
    sq[3] = dey * dey;
    for (int i = 0; i < 4; i++) q1_d[i] = sq[i][SW-1:0];
    s1_d.sx = item_i.start_x;
    s1_d.sy = item_i.start_y;
    s1_d.ex = item_i.end_x;
    s1_d.ey = item_i.end_y;
    s1_d.fx = item_i.far_x;
    s1_d.fy = item_i.far_y;
    s1_d.bh = item_i.box_height;
    s1_d.dx = $signed({1'b0, cx}) - $signed({2'b00, item_i.start_x});
    s1_d.dy = $signed({1'b0, cy}) - $signed({2'b00, item_i.start_y});
    s1_d.dzero = (cx == {1'b0, item_i.start_x}) && (cy == {1'b0, item_i.start_y});
  end

  // stage 2: squared distances of S and E from F
  logic [QW-1:0] d1_q, d2_q;

  // stage 3: farther point A, vectors A->B and A->F, length terms
  logic signed [DW-1:0] px_q, py_q, qx_q, qy_q;
  logic signed [VW-1:0] dx3_q, dy3_q;
  logic [LW-1:0] l2_q, l24_q;
  logic [HW-1:0] lo_q, hi_q;
  fdf_side_t side3_q, side4_q, side5_q, side6_q, side3_d, side5_d;
  logic [COORD_BITS-1:0] ax, ay, bx, by;

  always_comb begin
    if (d1_q < d2_q) begin
      ax = s2_q.ex; ay = s2_q.ey; bx = s2_q.sx; by = s2_q.sy;
    end else begin
      ax = s2_q.sx; ay = s2_q.sy; bx = s2_q.ex; by = s2_q.ey;
    end
    side3_d.vld    = v2_q;
    side3_d.bad    = s2_q.dzero || ((bx == ax) && (by == ay))
                     || ((s2_q.fx == ax) && (s2_q.fy == ay));
    side3_d.len_ok = 1'b0;
    side3_d.tip_x  = s2_q.sx;
    side3_d.tip_y  = s2_q.sy;
  end

  // stage 4: products
  logic signed [PW-1:0] c1_q, c2_q, t1_q, t2_q;
  logic [2*HW-1:0] lo2_q, hi2_q;
  logic signed [VW-1:0] dx4_q, dy4_q, dx5_q, dy5_q;

  // stage 5: |cross|, dot, length window
  logic signed [RW-1:0] cr_q, dt_q;
  logic signed [RW-1:0] crs;

  assign crs = RW'(c1_q) - RW'(c2_q);

  // limits squared can use the full product width
  always_comb begin
    side5_d        = side4_q;
    side5_d.len_ok = ((2*HW)'(l24_q) > lo2_q) && ((2*HW)'(l24_q) < hi2_q);
  end

  // stage 6: pre-rotation of vectors in the left half plane
  function automatic fdf_vec_t prerot(input logic signed [CW-1:0] y,
                                      input logic signed [CW-1:0] x);
    fdf_vec_t v;
    v.x = x; v.y = y; v.z = '0;
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        v.x = y; v.y = -x; v.z = ZW'(90) <<< ACC_FRAC;
      end else begin
        v.x = -y; v.y = x; v.z = -(ZW'(90) <<< ACC_FRAC);
      end
    end
    return v;
  endfunction

  fdf_vec_t dir_q, inr_q;

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    q1_q  <= q1_d;
    s2_q  <= s1_q;
    d1_q  <= QW'(q1_q[0]) + QW'(q1_q[1]);
    d2_q  <= QW'(q1_q[2]) + QW'(q1_q[3]);
    px_q  <= $signed({1'b0, bx}) - $signed({1'b0, ax});
    py_q  <= $signed({1'b0, by}) - $signed({1'b0, ay});
    qx_q  <= $signed({1'b0, s2_q.fx}) - $signed({1'b0, ax});
    qy_q  <= $signed({1'b0, s2_q.fy}) - $signed({1'b0, ay});
    dx3_q <= s2_q.dx;
    dy3_q <= s2_q.dy;
    l2_q  <= LW'(d1_q) * LW'(10000);
    lo_q  <= HW'(cfg_i.len_min) * HW'(s2_q.bh);
    hi_q  <= HW'(cfg_i.len_max) * HW'(s2_q.bh);
    c1_q  <= px_q * qy_q;
    c2_q  <= py_q * qx_q;
    t1_q  <= px_q * qx_q;
    t2_q  <= py_q * qy_q;
    lo2_q <= lo_q * lo_q;
    hi2_q <= hi_q * hi_q;
    l24_q <= l2_q;
    dx4_q <= dx3_q;
    dy4_q <= dy3_q;
    cr_q  <= crs[RW-1] ? -crs : crs;
    dt_q  <= RW'(t1_q) + RW'(t2_q);
    dx5_q <= dx4_q;
    dy5_q <= dy4_q;
    dir_q <= prerot(CW'(dy5_q) <<< SCALE_SH, CW'(dx5_q) <<< SCALE_SH);
    inr_q <= prerot(CW'(cr_q) <<< SCALE_SH, CW'(dt_q) <<< SCALE_SH);
  end

  // valid bits and side tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
      side6_q <= '0;
    end else begin
      v1_q    <= vld_i;
      v2_q    <= v1_q;
      side3_q <= side3_d;
      side4_q <= side3_q;
      side5_q <= side5_d;
      side6_q <= side5_q;
    end
  end

  assign dir_o  = dir_q;
  assign inr_o  = inr_q;
  assign side_o = side6_q;
endmodule

// File: hdl/fdf_checker.sv
module fdf_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input fdf_pkg::fdf_item_t   item_i,
  input logic                 done_o,
  input fdf_pkg::fdf_result_t result_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);
  import fdf_pkg::*;

  localparam int unsigned LAT = 35;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##35 done_o)
    else $error("item accepted without a result after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  a_tip_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.tip_x == $past(item_i.start_x, LAT))
            && (result_o.tip_y == $past(item_i.start_y, LAT)))
    else $error("start point not passed through");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind fingertip_defect_filter_unit fdf_checker u_fdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .done_o      (done_o),
  .result_o    (result_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
